// ----- rtl/kmp_pkg.sv -----
// Shared types and constants for the KMP substring search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kmp_pkg;

    // Default sizes of the pattern store and the text position counter
    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    // Configuration port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LENGTH_W    = 5;
    localparam int START_W     = 16;
    localparam int MATCH_POS_W = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 2'd3;

    // Control handed to every cell of the match chain
    typedef struct packed {
        logic advance;  // a compared byte moves the partial-match flags
        logic clear;    // drop every partial match
    } cell_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic [MATCH_POS_W-1:0] match_position;
        logic                   found;
    } result_t;

endpackage

// ----- rtl/kmp_cell.sv -----
// One cell of the match chain: holds the partial-match flag for one pattern byte.
// Depends on kmp_pkg for the cell control struct.
`timescale 1ns / 1ps

module kmp_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  kmp_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         text_byte,
    input  logic [7:0]         pattern_byte,
    input  logic               carry_in,
    output logic               hit,
    output logic               active
);
    import kmp_pkg::*;

    logic active_reg;
    logic active_next;

    // Extend the neighbor's partial match by this cell's byte
    assign hit = carry_in && (text_byte == pattern_byte);

    // Clear wins over advance; otherwise hold
    always_comb
    begin
        active_next = active_reg;
        if (ctrl.clear)
        begin
            active_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            active_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

// ----- rtl/kmp_out_buffer.sv -----
// Result output register with one skid entry behind it.
// Depends on kmp_pkg for the result struct.
`timescale 1ns / 1ps

module kmp_out_buffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kmp_pkg::result_t push_data,
    input  logic             out_stall,
    output logic             skid_full,
    output logic             out_valid,
    output kmp_pkg::result_t out_data
);
    import kmp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    assign take = out_valid_reg && !out_stall;

    // Refill the output slot from skid first, then from a new push
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/kmp_substring_search_top.sv -----
// Top level of the KMP substring search: configuration, position tracking,
// match cell chain and result buffer. Depends on kmp_pkg, kmp_cell, kmp_out_buffer.
`timescale 1ns / 1ps

// Usage:
//   Configure pattern_length, the pattern bytes and start_position through the
//   write port (cfg_write_en, cfg_index, cfg_data) while no text is in flight.
//   Stream text on the input channel (in_valid/in_stall), one byte per
//   transaction, text_last on the final byte of each text.
//   For each text at most one result transaction leaves on the output channel:
//   found=1 with the 1-based start of the first match, or found=0 with
//   position 0 when the last byte passes without a match.
//   Throughput: one byte per cycle while in_stall is low. Each pattern byte
//   has a cell in a chain that keeps a partial-match flag and passes it to the
//   next cell per byte, so a byte is resolved in the cycle it is accepted.
//   Each result is registered into the output register.
//   A stalled receiver holds the output register; one more result is caught
//   in a skid entry, and only while that entry is full is in_stall raised.
//   Reset: pattern length 1, pattern bytes zero, start position 1, no partial
//   matches, position zero. No clearing pass is needed.
//   Writing the length or pattern bytes drops partial matches mid-text.

module kmp_substring_search_top #(
    parameter int PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [kmp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        text_byte,
    input  logic                              text_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kmp_pkg::MATCH_POS_W-1:0]   match_position,
    output logic                              found
);
    import kmp_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Configuration registers
    logic [LENGTH_W-1:0]   len_reg;
    logic [CFG_DATA_W-1:0] pat_lo_reg;
    logic [CFG_DATA_W-1:0] pat_hi_reg;
    logic [START_W-1:0]    start_reg;

    // Search state
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     done_reg;
    logic                     done_next;

    logic                     accept;
    logic                     pattern_write;
    logic [LEN_W-1:0]         len_eff;
    logic [IDX_W-1:0]         len_idx;
    logic [POSITION_BITS-1:0] pos_inc;
    logic                     compare_en;
    logic                     matched;
    logic                     push;
    logic                     skid_full;
    logic [CMP_W-1:0]         match_pos_wide;
    result_t                  push_data;
    result_t                  out_data;
    cell_ctrl_t               ctrl;
    logic [PATTERN_MAX-1:0]   hit;
    logic [PATTERN_MAX-1:0]   active;

    assign accept = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LENGTH_W'(1);
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            start_reg  <= START_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: len_reg    <= cfg_data[LENGTH_W-1:0];
                REG_PATTERN_LOW:    pat_lo_reg <= cfg_data;
                REG_PATTERN_HIGH:   pat_hi_reg <= cfg_data;
                REG_START_POSITION: start_reg  <= cfg_data[START_W-1:0];
                default:            ;
            endcase
        end
    end

    assign pattern_write = cfg_write_en && (cfg_index != REG_START_POSITION);

    // Clamp the length into 1..PATTERN_MAX
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > LENGTH_W'(PATTERN_MAX))
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = len_reg[LEN_W-1:0];
        end
    end

    assign len_idx = IDX_W'(len_eff - LEN_W'(1));

    // Saturating position of the byte being accepted
    assign pos_inc    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);
    assign compare_en = !done_reg && (CMP_W'(pos_inc) >= CMP_W'(start_reg));

    // Match chain
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [7:0] pat_byte;
            logic       carry;
            if (k < 8)
            begin : g_low
                assign pat_byte = pat_lo_reg[8*k +: 8];
            end
            else
            begin : g_high
                assign pat_byte = pat_hi_reg[8*(k-8) +: 8];
            end
            if (k == 0)
            begin : g_head
                assign carry = 1'b1;
            end
            else
            begin : g_link
                assign carry = active[k-1];
            end
            kmp_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .text_byte    (text_byte),
                .pattern_byte (pat_byte),
                .carry_in     (carry),
                .hit          (hit[k]),
                .active       (active[k])
            );
        end
    endgenerate

    assign matched = compare_en && hit[len_idx];

    // Advance on compared bytes; drop partial matches on match, last byte or new pattern
    assign ctrl.advance = accept && compare_en;
    assign ctrl.clear   = pattern_write || (accept && (text_last || matched));

    // Build the result of the current byte
    assign match_pos_wide = CMP_W'(pos_inc) - CMP_W'(len_eff) + CMP_W'(1);
    assign push = accept && (matched || (text_last && !done_reg));
    assign push_data.found          = matched;
    assign push_data.match_position = matched ? match_pos_wide[MATCH_POS_W-1:0] : '0;

    // Track position and first-match flag; restart on the last byte
    always_comb
    begin
        pos_next  = pos_reg;
        done_next = done_reg;
        if (accept)
        begin
            if (text_last)
            begin
                pos_next  = '0;
                done_next = 1'b0;
            end
            else
            begin
                pos_next  = pos_inc;
                done_next = done_reg || matched;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // Result buffer
    kmp_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_stall (out_stall),
        .skid_full (skid_full),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign in_stall       = skid_full;
    assign match_position = out_data.match_position;
    assign found          = out_data.found;

    // A held skid entry always sits behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> out_valid)
        else $error("skid entry full while output register empty");

    // A transaction with no match carries position zero
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_position == '0))
        else $error("no-match result with nonzero position");

    // Writing the pattern drops every partial match
    a_pattern_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_write |=> (active == '0))
        else $error("partial matches survived a pattern write");

    // Once the first match is reported the chain stops advancing
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !ctrl.advance)
        else $error("chain advanced after the first match");

endmodule
